// ----- hdl/subtitle_coverage_alpha_compositor_defines.svh -----
// Assertion macros used by the checker file scac_checker.sv.
`ifndef SUBTITLE_COVERAGE_ALPHA_COMPOSITOR_DEFINES_SVH
`define SUBTITLE_COVERAGE_ALPHA_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/scac_pkg.sv -----
package scac_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0]  REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RST    = 11'd1024;

  localparam logic [1:0] OP_BLEND = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic capture;
    logic locate;
    logic mem_rd;
    logic mix;
    logic commit;
    logic clr_step;
  } scac_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
  } scac_sts_t;

  // floor(x/255) for x <= 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ----- hdl/scac_in_if.sv -----
interface scac_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         coverage;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         color_alpha;

  modport source (output valid, op, pos_x, pos_y, coverage, red, green, blue,
                  color_alpha, input ready);
  modport sink (input valid, op, pos_x, pos_y, coverage, red, green, blue,
                color_alpha, output ready);
endinterface

// ----- hdl/scac_out_if.sv -----
interface scac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_opacity;
  logic       in_frame;

  modport source (output valid, out_red, out_green, out_blue, out_opacity, in_frame,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_opacity, in_frame,
                output ready);
endinterface

// ----- hdl/subtitle_coverage_alpha_compositor.sv -----
// A read result passes locate, store read and mix and is registered into the output at commit.
// Items are taken one at a time through five states (accept, locate, store read, mix, commit);
//   the frame store is read and written in separate states of each item.
// A read result that waits in the output register stalls the next read at commit.
// Reset: synchronous, active low; afterwards a clearing sweep writes every pixel,
//   MAX_WIDTH*MAX_HEIGHT of them (1048576 by default), to transparent, with ready low.
module subtitle_coverage_alpha_compositor
  import scac_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  scac_in_if.sink               in_if,
  scac_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  scac_cmd_t cmd;
  scac_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  scac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scac_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .op          (in_if.op),
    .pos_x       (in_if.pos_x),
    .pos_y       (in_if.pos_y),
    .coverage    (in_if.coverage),
    .red         (in_if.red),
    .green       (in_if.green),
    .blue        (in_if.blue),
    .color_alpha (in_if.color_alpha),
    .out_red     (out_if.out_red),
    .out_green   (out_if.out_green),
    .out_blue    (out_if.out_blue),
    .out_opacity (out_if.out_opacity),
    .in_frame    (out_if.in_frame)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

endmodule

// ----- hdl/scac_ctrl.sv -----
module scac_ctrl
  import scac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  scac_sts_t sts,
  output scac_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOC    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_MIX    = 3'd4;
  localparam logic [2:0] ST_COMMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOC;
        end
      end
      ST_LOC: begin
        cmd.locate = 1'b1;
        state_nxt  = ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // a read result waits while the output register still holds one
        if (!(sts.is_read && out_valid_r && !out_ready)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit && sts.is_read) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/scac_dp.sv -----
module scac_dp
  import scac_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scac_cmd_t             cmd,
  output scac_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            op,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  input  logic [7:0]            coverage,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            color_alpha,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_opacity,
  output logic                  in_frame
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam logic [15:0]       MAXW16   = 16'(MAX_WIDTH);
  localparam logic [15:0]       MAXH16   = 16'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(DEPTH - 1);

  logic [31:0] mem [DEPTH];

  logic [CFG_DATA_W-1:0] fw_r, fh_r;
  logic [ADDR_W-1:0]     clr_cnt_r;

  logic [1:0]  op_r;
  logic [15:0] x_r, y_r;
  logic [7:0]  cov_r, ga_r;
  logic [7:0]  col_r [3];

  logic              inside_r;
  logic [ADDR_W-1:0] addr_r;
  logic [15:0]       prod_r;
  logic [7:0]        alpha_r;
  logic [31:0]       rdata_r;
  logic [15:0]       sum_r [3];
  logic [15:0]       bga_r;

  logic [7:0]  out_red_r, out_green_r, out_blue_r, out_opacity_r;
  logic        in_frame_r;

  logic [15:0]       w_lim, h_lim;
  logic              inside_nxt;
  logic [ADDR_W-1:0] addr_nxt;
  logic [7:0]        inv_a;
  logic [31:0]       blend_px;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_DIM_RST;
      fh_r <= FRAME_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  fw_r <= cfg_data;
        REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step && clr_cnt_r != LAST_ADR) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // clip and address
  always_comb begin
    w_lim      = ({5'd0, fw_r} < MAXW16) ? {5'd0, fw_r} : MAXW16;
    h_lim      = ({5'd0, fh_r} < MAXH16) ? {5'd0, fh_r} : MAXH16;
    inside_nxt = !x_r[15] && !y_r[15] && (x_r < w_lim) && (y_r < h_lim);
    addr_nxt   = ADDR_W'(ADDR_W'(y_r[YW-1:0]) * ADDR_W'(MAX_WIDTH))
               + ADDR_W'(x_r[XW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op;
      x_r      <= pos_x;
      y_r      <= pos_y;
      cov_r    <= coverage;
      ga_r     <= color_alpha;
      col_r[0] <= red;
      col_r[1] <= green;
      col_r[2] <= blue;
    end
    if (cmd.locate) begin
      inside_r <= inside_nxt;
      addr_r   <= addr_nxt;
      prod_r   <= {8'd0, ga_r} * {8'd0, cov_r};
    end
    if (cmd.mem_rd) begin
      alpha_r <= div255(prod_r);
    end
  end

  assign inv_a = 8'hFF - alpha_r;

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= {8'd0, col_r[i]} * {8'd0, alpha_r}
                  + {8'd0, rdata_r[8*i +: 8]} * {8'd0, inv_a};
      end
      bga_r <= {8'd0, rdata_r[31:24]} * {8'd0, inv_a};
    end
  end

  always_comb begin
    if (rdata_r[31:24] == 8'd0) begin
      blend_px = {alpha_r, col_r[2], col_r[1], col_r[0]};
    end else begin
      blend_px = {8'(alpha_r + div255(bga_r)), div255(sum_r[2]),
                  div255(sum_r[1]), div255(sum_r[0])};
    end
  end

  // one write port: clearing sweep or commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = blend_px;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.commit && inside_r) begin
      case (op_r)
        OP_BLEND: wr_en = (alpha_r != 8'd0);
        OP_CLEAR: begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op_r == OP_READ) begin
      out_red_r     <= inside_r ? rdata_r[7:0]   : 8'd0;
      out_green_r   <= inside_r ? rdata_r[15:8]  : 8'd0;
      out_blue_r    <= inside_r ? rdata_r[23:16] : 8'd0;
      out_opacity_r <= inside_r ? rdata_r[31:24] : 8'd0;
      in_frame_r    <= inside_r;
    end
  end

  assign sts.clr_last = (clr_cnt_r == LAST_ADR);
  assign sts.is_read  = (op_r == OP_READ);

  assign out_red     = out_red_r;
  assign out_green   = out_green_r;
  assign out_blue    = out_blue_r;
  assign out_opacity = out_opacity_r;
  assign in_frame    = in_frame_r;

endmodule

// ----- hdl/scac_checker.sv -----
`include "subtitle_coverage_alpha_compositor_defines.svh"

module scac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_opacity,
  input logic       in_frame
);

  logic [32:0] res;

  assign res = {in_frame, out_opacity, out_blue, out_green, out_red};

  `SCAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res), "result not held")

  `SCAC_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready), "result dropped without transfer")

  // off-frame reads report a zero pixel
  `SCAC_ASSERT_NOW(a_off_zero, out_valid && !in_frame, res[31:0] == 32'd0, "off-frame read not zero")

  // one item at a time: ready drops after every input transfer
  `SCAC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind subtitle_coverage_alpha_compositor scac_checker u_scac_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_red     (out_if.out_red),
  .out_green   (out_if.out_green),
  .out_blue    (out_if.out_blue),
  .out_opacity (out_if.out_opacity),
  .in_frame    (out_if.in_frame)
);
